// File: rtl/lzxe8_pkg.sv
// Package for the LZX E8 call untranslation block.
// Holds the word types, the gather state and the constants shared by all files.
// No dependencies.
package lzxe8_pkg;

  localparam int MAX_BLOCK_DEF = 32768;
  localparam int OFFSET_BYTES  = 4;
  localparam int TAIL_GUARD    = 11;
  localparam int PADDR_W       = 3;

  localparam logic [7:0] CALL_OPCODE   = 8'hE8;
  // Register select is paddr[2]; the file size register is register zero.
  localparam logic       REG_FILE_SIZE = 1'b0;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] block_length;
    logic        stream_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       block_end;
  } out_word_t;

  // count: 0 idle, 1..4 collecting the call operand, count-1 bytes held.
  typedef struct packed {
    logic [2:0]  count;
    logic [23:0] bytes;
  } gather_t;

  // Bytes produced by one input word, first byte in entry zero.
  typedef struct packed {
    logic [2:0]                   n;
    logic [OFFSET_BYTES-1:0][7:0] bytes;
    logic [OFFSET_BYTES-1:0]      ends;
  } result_t;

endpackage

// File: rtl/lzxe8_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on lzxe8_pkg for the payload types.
interface lzxe8_in_if;
  import lzxe8_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lzxe8_out_if;
  import lzxe8_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/lzxe8_step.sv
// Combinational step of the E8 untranslation: from one input word and the current
// stream state, the bytes to release and the next state. Depends on lzxe8_pkg.
module lzxe8_step #(
  parameter int MAX_BLOCK = lzxe8_pkg::MAX_BLOCK_DEF,
  parameter int OFF_W     = $clog2(MAX_BLOCK)
) (
  input  lzxe8_pkg::in_word_t word,
  input  logic [31:0]         file_size,
  input  logic [31:0]         pos,
  input  logic [OFF_W-1:0]    off,
  input  lzxe8_pkg::gather_t  gath,
  input  logic [31:0]         call_pos,
  output lzxe8_pkg::result_t  res,
  output logic [31:0]         pos_next,
  output logic [OFF_W-1:0]    off_next,
  output lzxe8_pkg::gather_t  gath_next,
  output logic [31:0]         call_pos_next
);
  import lzxe8_pkg::*;

  logic              start;
  logic [7:0]        b;
  logic [16:0]       len;
  gather_t           g_e;
  logic [31:0]       pos_e;
  logic [OFF_W-1:0]  off_e;
  logic [16:0]       off17;
  logic              is_end;
  logic              guard_ok;
  logic [31:0]       v;
  logic [31:0]       r;
  logic [1:0]        k;
  logic [1:0]        held;
  logic              emit_b;
  logic [31:0]       src;

  always_comb begin
    start = word.stream_start;
    b     = word.data_byte;

    len = {1'b0, word.block_length};
    if (len == 17'd0) begin
      len = 17'd1;
    end else if (len > 17'(MAX_BLOCK)) begin
      len = 17'(MAX_BLOCK);
    end

    // A stream start drops any open call; its held bytes leave first.
    g_e   = start ? '0 : gath;
    pos_e = start ? 32'd0 : pos;
    off_e = start ? '0 : off;

    off17    = 17'(off_e);
    is_end   = (off17 + 17'd1) >= len;
    guard_ok = (off17 + 17'(TAIL_GUARD)) <= len;

    v = {b, g_e.bytes};
    if (v < file_size) begin
      r = v - call_pos;
    end else if (v[31] && ((32'd0 - v) <= call_pos)) begin
      r = v + file_size;
    end else begin
      r = v;
    end

    held = 2'(g_e.count - 3'd1);
    src  = {8'h00, gath.bytes};

    res           = '0;
    gath_next     = g_e;
    call_pos_next = call_pos;
    pos_next      = pos_e + 32'd1;
    off_next      = is_end ? '0 : off_e + OFF_W'(1);
    k             = 2'd0;
    emit_b        = 1'b0;

    if (start && gath.count > 3'd1) begin
      k = 2'(gath.count - 3'd1);
    end

    if (g_e.count == 3'(OFFSET_BYTES)) begin
      res.n     = 3'(OFFSET_BYTES);
      res.bytes = r;
      res.ends  = {is_end, 3'b000};
      gath_next = '0;
    end else if (g_e.count != 3'd0 && is_end) begin
      // Block ends inside the operand: release what is held, untouched.
      k         = held;
      emit_b    = 1'b1;
      gath_next = '0;
    end else if (g_e.count != 3'd0) begin
      gath_next.bytes = g_e.bytes | (24'(b) << {held, 3'b000});
      gath_next.count = g_e.count + 3'd1;
    end else begin
      emit_b = 1'b1;
      if (b == CALL_OPCODE && guard_ok) begin
        gath_next.count = 3'd1;
        gath_next.bytes = '0;
        call_pos_next   = pos_e;
      end
    end

    if (emit_b) begin
      for (int i = 0; i < OFFSET_BYTES; i++) begin
        if (i < int'(k)) begin
          res.bytes[i] = src[i*8 +: 8];
          res.ends[i]  = start && (i == int'(k) - 1);
        end else if (i == int'(k)) begin
          res.bytes[i] = b;
          res.ends[i]  = is_end;
        end
      end
      res.n = 3'(k) + 3'd1;
    end
  end

endmodule

// File: rtl/lzx_e8_call_untranslate_core.sv
// Top level of the LZX E8 call untranslation block: input register, step logic,
// result buffer and APB register. Depends on lzxe8_pkg, lzxe8_if.sv, lzxe8_step.
//
//  channel   role     word                                     handshake
//  stream    sink     data_byte, block_length, stream_start    valid/ready
//  result    source   out_byte, run_last, block_end            valid/ready
//  APB       slave    file_size at byte address 0              psel/penable
//
// A word is registered on acceptance and resolved once the buffer is free, into
// zero to four result bytes, which a four-entry result buffer hands out one per
// cycle while result.ready is high. Throughput is one word per cycle while each
// word yields at most one byte and result.ready is high; the result port sets it
// otherwise. A new word is resolved in the cycle the buffer's last byte is taken.
// Reset clears the stream position, block offset, open call and file size.
module lzx_e8_call_untranslate_core #(
  parameter int MAX_BLOCK = lzxe8_pkg::MAX_BLOCK_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  lzxe8_in_if.sink                      stream,
  lzxe8_out_if.source                   result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lzxe8_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lzxe8_pkg::*;

  localparam int OFF_W = $clog2(MAX_BLOCK);

  logic [31:0]      file_size;

  logic             s1_valid;
  in_word_t         s1_word;
  logic             take;

  logic [31:0]      pos;
  logic [OFF_W-1:0] off;
  gather_t          gath;
  logic [31:0]      call_pos;

  result_t          res;
  logic [31:0]      pos_next;
  logic [OFF_W-1:0] off_next;
  gather_t          gath_next;
  logic [31:0]      call_pos_next;

  logic [2:0]                   rem;
  logic [OFFSET_BYTES-1:0][7:0] ob_bytes;
  logic [OFFSET_BYTES-1:0]      ob_ends;
  logic                         out_fire;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FILE_SIZE) ? file_size : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_FILE_SIZE) begin
      file_size <= pwdata;
    end
  end

  // The buffer is free when empty or when its last byte leaves this cycle.
  assign out_fire     = result.valid && result.ready;
  assign take         = s1_valid && (rem == 3'd0 || (rem == 3'd1 && result.ready));
  assign stream.ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      s1_word <= stream.data;
    end
  end

  lzxe8_step #(
    .MAX_BLOCK (MAX_BLOCK),
    .OFF_W     (OFF_W)
  ) u_step (
    .word          (s1_word),
    .file_size     (file_size),
    .pos           (pos),
    .off           (off),
    .gath          (gath),
    .call_pos      (call_pos),
    .res           (res),
    .pos_next      (pos_next),
    .off_next      (off_next),
    .gath_next     (gath_next),
    .call_pos_next (call_pos_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      off      <= '0;
      gath     <= '0;
      call_pos <= '0;
    end else if (take) begin
      pos      <= pos_next;
      off      <= off_next;
      gath     <= gath_next;
      call_pos <= call_pos_next;
    end
  end

  // Result buffer: entry zero is the head; it shifts down as bytes leave.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (take) begin
      rem <= res.n;
    end else if (out_fire) begin
      rem <= rem - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ob_bytes <= res.bytes;
      ob_ends  <= res.ends;
    end else if (out_fire) begin
      ob_bytes <= {8'h00, ob_bytes[OFFSET_BYTES-1:1]};
      ob_ends  <= {1'b0, ob_ends[OFFSET_BYTES-1:1]};
    end
  end

  assign result.valid          = rem != 3'd0;
  assign result.data.out_byte  = ob_bytes[0];
  assign result.data.block_end = ob_ends[0];
  assign result.data.run_last  = rem == 3'd1;

endmodule

// File: rtl/lzxe8_chk.sv
// Port-level checker for the E8 untranslation core, bound to the top level.
// Depends on lzxe8_pkg and on the port names of lzx_e8_call_untranslate_core.
module lzxe8_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input lzxe8_pkg::out_word_t          out_data,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [lzxe8_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                   pwdata,
  input logic [31:0]                   prdata,
  input logic                          pready
);
  import lzxe8_pkg::*;

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A written file size reads back in the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[2] == REG_FILE_SIZE)
      ##1 (paddr[2] == REG_FILE_SIZE) |-> prdata == $past(pwdata))
    else $error("file size readback mismatch");

  // A word taken without run_last is followed at once by another word of the
  // same item, since the rest of that item is already in the buffer.
  a_last_then_new: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.run_last |=> out_valid)
    else $error("result run ended without run_last");

endmodule

bind lzx_e8_call_untranslate_core lzxe8_chk u_lzxe8_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
